/* design/tw_pkg.sv */
// ----------------------------------------------------------------------------
// Timing wheel package
// Shared item types and codes for the timing wheel slot lists block.
// ----------------------------------------------------------------------------
package tw_pkg;

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_REMOVE  = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_STRAY = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [0:0] REG_SLOTS = 1'b0;
  localparam logic [0:0] REG_MODE  = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] node_id;
    logic [6:0] advance_slots;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] visited_node;
    logic [5:0] slot_index;
    logic       last;
  } out_item_t;

endpackage

/* design/timing_wheel_slot_lists.sv */
// ----------------------------------------------------------------------------
// Timing wheel slot lists
// A wheel of slots, each a doubly linked list of pool nodes, with insert,
// remove and advance.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_ready with a packed in_item_t; result
// items leave on out_valid/out_ready as out_item_t, the last one of an input
// item flagged by last. Configuration is a plain write port (cfg_we, cfg_addr,
// cfg_data); the user must write it only while the block is idle, and the block does not enforce it.
// One item is worked at a time, and in_ready is high only while idle. An
// insert, a remove or a double insert passes from S_RD through S_INS or
// S_REM to S_OUT, where its result is loaded into the output register. A stray
// remove or a node outside the pool goes from S_RD straight to S_OUT, and an
// unknown mode returns to idle with no result. An advance reads the head of
// each slot it passes and then the node memory for each node it visits, both
// memories being read through a register.
// A result waits in the output register while the receiver stalls, and the
// walk and the final result wait until it is taken.
// Reset clears the cursors, the mode bit and the node and slot valid bits; the
// slot heads carry one valid bit per slot in flip-flops, so no clearing pass is
// needed and the block accepts items from the first cycle after reset.
// ----------------------------------------------------------------------------
module timing_wheel_slot_lists
  import tw_pkg::*;
#(
  parameter int NUM_SLOTS  = 64,
  parameter int NODE_COUNT = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_addr,
  input  logic [6:0] cfg_data
);

  localparam int CAP = (NUM_SLOTS < 64) ? NUM_SLOTS : 64;
  localparam logic [6:0] CAP7 = 7'(CAP);
  localparam logic [6:0] NIL = 7'd64;
  localparam logic [6:0] NODES7 = 7'(NODE_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_INS, S_REM, S_ADV_SLOT, S_ADV_HEAD, S_ADV_NODE,
    S_ADV_NEXT, S_OUT
  } state_t;

  state_t state;
  in_item_t item;
  logic [6:0] slots_in_use;
  logic       round_robin;
  logic [5:0] wheel_cursor, insert_cursor;

  logic [6:0] slot_head [64];
  logic [63:0] slot_vld;
  logic [6:0] nnext [64];
  logic [6:0] nprev [64];
  logic [5:0] nhome [64];
  logic [63:0] linked;

  logic [6:0] rd_next, rd_prev;
  logic [5:0] rd_home;
  logic [5:0] rd_addr;
  logic [6:0] head_q;
  logic       head_vld_q;
  logic [5:0] head_addr;
  logic [6:0] head_rd;

  logic [6:0] n_slots, adv_left, cur, count;
  logic [5:0] idx, walk_slot, cur_wc, wc_step, ins_slot;
  logic       found;
  out_item_t  res, pend, load_data;
  logic       can_load, load;

  always_comb begin
    n_slots = slots_in_use;
    if (n_slots == 7'd0) n_slots = 7'd1;
    if (n_slots > CAP7) n_slots = CAP7;
  end

  assign cur_wc = ({1'b0, wheel_cursor} >= n_slots) ? 6'd0 : wheel_cursor;
  assign wc_step = ({1'b0, cur_wc} + 7'd1 >= n_slots) ? 6'd0 : cur_wc + 6'd1;
  assign ins_slot = !round_robin ? cur_wc
                  : ({1'b0, insert_cursor} + 7'd1 >= n_slots) ? 6'd0
                  : insert_cursor + 6'd1;

  assign in_ready = (state == S_IDLE);
  assign can_load = !out_valid || out_ready;
  assign head_addr = (state == S_ADV_SLOT) ? cur_wc : ins_slot;
  assign rd_addr = (state == S_ADV_NODE) ? cur[5:0] : item.node_id;
  assign head_rd = head_vld_q ? head_q : NIL;

  always_ff @(posedge clk) begin
    rd_next <= nnext[rd_addr];
    rd_prev <= nprev[rd_addr];
    rd_home <= nhome[rd_addr];
    head_q <= slot_head[head_addr];
    head_vld_q <= slot_vld[head_addr];
  end

  always_comb begin
    load = 1'b0;
    load_data = res;
    if (state == S_OUT) begin
      load = can_load;
    end else if (state == S_ADV_NODE) begin
      load = found && can_load;
      load_data = pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slots_in_use <= 7'd64;
      round_robin <= 1'b0;
      wheel_cursor <= '0;
      insert_cursor <= '0;
      slot_vld <= '0;
      linked <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SLOTS: slots_in_use <= cfg_data;
          REG_MODE:  round_robin <= cfg_data[0];
          default: ;
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
        out_data <= load_data;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            state <= S_RD;
          end
        end
        S_RD: begin
          res <= '{status: ST_STRAY, visited_node: item.node_id, slot_index: 6'd0,
                   last: 1'b1};
          case (item.mode)
            MODE_INSERT: begin
              if ({1'b0, item.node_id} >= NODES7) state <= S_OUT;
              else if (linked[item.node_id]) state <= S_REM;
              else begin
                idx <= ins_slot;
                if (round_robin) insert_cursor <= ins_slot;
                else wheel_cursor <= cur_wc;
                nprev[item.node_id] <= NIL;
                state <= S_INS;
              end
            end
            MODE_REMOVE: begin
              if ({1'b0, item.node_id} >= NODES7 || !linked[item.node_id])
                state <= S_OUT;
              else state <= S_REM;
            end
            MODE_ADVANCE: begin
              adv_left <= (item.advance_slots > n_slots) ? n_slots
                          : item.advance_slots;
              count <= '0;
              found <= 1'b0;
              state <= S_ADV_SLOT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_INS: begin
          if (head_rd != NIL) nprev[head_rd[5:0]] <= {1'b0, item.node_id};
          nnext[item.node_id] <= head_rd;
          nhome[item.node_id] <= idx;
          linked[item.node_id] <= 1'b1;
          slot_head[idx] <= {1'b0, item.node_id};
          slot_vld[idx] <= 1'b1;
          res.status <= ST_OK;
          res.slot_index <= idx;
          state <= S_OUT;
        end
        S_REM: begin
          res.slot_index <= rd_home;
          if (item.mode == MODE_INSERT) res.status <= ST_DUP;
          else begin
            res.status <= ST_OK;
            if (rd_next != NIL) nprev[rd_next[5:0]] <= rd_prev;
            if (rd_prev != NIL) nnext[rd_prev[5:0]] <= rd_next;
            else slot_head[rd_home] <= rd_next;
            linked[item.node_id] <= 1'b0;
          end
          state <= S_OUT;
        end
        S_ADV_SLOT: begin
          if (adv_left == 7'd0) begin
            if (found) begin
              res <= '{status: pend.status, visited_node: pend.visited_node,
                       slot_index: pend.slot_index, last: 1'b1};
            end else begin
              res <= '{status: ST_EMPTY, visited_node: 6'd0, slot_index: 6'd0,
                       last: 1'b1};
            end
            state <= S_OUT;
          end else begin
            walk_slot <= cur_wc;
            wheel_cursor <= wc_step;
            adv_left <= adv_left - 7'd1;
            state <= S_ADV_HEAD;
          end
        end
        S_ADV_HEAD: begin
          cur <= head_rd;
          state <= (head_rd != NIL && count < 7'd64) ? S_ADV_NODE : S_ADV_SLOT;
        end
        S_ADV_NODE: begin
          if (!found || can_load) begin
            pend <= '{status: ST_OK, visited_node: cur[5:0], slot_index: walk_slot,
                      last: 1'b0};
            found <= 1'b1;
            count <= count + 7'd1;
            state <= S_ADV_NEXT;
          end
        end
        S_ADV_NEXT: begin
          cur <= rd_next;
          state <= (rd_next != NIL && count < 7'd64) ? S_ADV_NODE : S_ADV_SLOT;
        end
        S_OUT: begin
          if (can_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid || $past(out_valid))
    else $error("result raised on accept");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_EMPTY) |-> out_data.last)
    else $error("empty advance result without last");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && out_valid) |-> out_data.last)
    else $error("item finished without last result");

endmodule

/* dv/timing_wheel_slot_lists_tb.sv */
// ----------------------------------------------------------------------------
// Timing wheel slot lists testbench
// Drives insert, remove, advance and unknown-mode items through the valid/ready
// input, predicts the result items from a model of the slot lists kept here,
// and checks each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module timing_wheel_slot_lists_tb;
  import tw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int NODES = 64;
  localparam logic [6:0] EMPTY_HEAD = 7'd64;
  localparam logic [6:0] SLOT_SETTINGS [6] = '{7'd64, 7'd1, 7'd2, 7'd0, 7'd127, 7'd5};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [6:0] cfg_data = '0;

  always #4 clk = ~clk;

  timing_wheel_slot_lists dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Shadow copy of the wheel.
  logic [6:0] head_of_slot [SLOTS];
  logic [6:0] next_of_node [NODES];
  logic [6:0] prev_of_node [NODES];
  logic [5:0] home_of_node [NODES];
  logic       node_on_wheel [NODES];
  logic [5:0] cursor;
  logic [5:0] ins_cursor;
  logic [6:0] slots_reg;
  logic       round_robin;

  out_item_t pending_results [$];
  int errors = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  function automatic int active_slots();
    int n;
    n = int'(slots_reg);
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  function automatic out_item_t mk(logic [1:0] st, logic [5:0] nd, logic [5:0] sl,
                                   logic lst);
    out_item_t r;
    r.status = st;
    r.visited_node = nd;
    r.slot_index = sl;
    r.last = lst;
    return r;
  endfunction

  // Updates the shadow wheel and queues the result items of one input item.
  task automatic predict_wheel(in_item_t it);
    int n, idx, cnt, k, steps, nd;
    logic [6:0] h, nx, pv, cur;
    logic [5:0] home;
    n = active_slots();
    nd = int'(it.node_id);
    case (it.mode)
      MODE_INSERT: begin
        if (nd >= NODES) begin
          pending_results.push_back(mk(ST_STRAY, 6'(nd), 6'd0, 1'b1));
        end else if (node_on_wheel[nd]) begin
          pending_results.push_back(mk(ST_DUP, 6'(nd), home_of_node[nd], 1'b1));
        end else begin
          if (round_robin) begin
            idx = int'(ins_cursor) + 1;
            if (idx >= n) idx = 0;
            ins_cursor = 6'(idx);
          end else begin
            if (int'(cursor) >= n) cursor = '0;
            idx = int'(cursor);
          end
          h = head_of_slot[idx];
          if (h < EMPTY_HEAD) prev_of_node[h[5:0]] = 7'(nd);
          next_of_node[nd] = h;
          prev_of_node[nd] = EMPTY_HEAD;
          home_of_node[nd] = 6'(idx);
          node_on_wheel[nd] = 1'b1;
          head_of_slot[idx] = 7'(nd);
          pending_results.push_back(mk(ST_OK, 6'(nd), 6'(idx), 1'b1));
        end
      end
      MODE_REMOVE: begin
        if (nd >= NODES || !node_on_wheel[nd]) begin
          pending_results.push_back(mk(ST_STRAY, 6'(nd), 6'd0, 1'b1));
        end else begin
          nx = next_of_node[nd];
          pv = prev_of_node[nd];
          home = home_of_node[nd];
          if (nx < EMPTY_HEAD) prev_of_node[nx[5:0]] = pv;
          if (pv < EMPTY_HEAD) next_of_node[pv[5:0]] = nx;
          else head_of_slot[home] = nx;
          node_on_wheel[nd] = 1'b0;
          pending_results.push_back(mk(ST_OK, 6'(nd), home, 1'b1));
        end
      end
      MODE_ADVANCE: begin
        cnt = int'(it.advance_slots);
        if (cnt > n) cnt = n;
        k = 0;
        for (int i = 0; i < cnt; i++) begin
          idx = int'(cursor);
          if (idx >= n) idx = 0;
          cursor = (idx + 1 >= n) ? 6'd0 : 6'(idx + 1);
          cur = head_of_slot[idx];
          steps = 0;
          while (cur < EMPTY_HEAD && steps < 64 && k < 64) begin
            pending_results.push_back(mk(ST_OK, cur[5:0], 6'(idx), 1'b0));
            k++;
            steps++;
            cur = next_of_node[cur[5:0]];
          end
        end
        if (k == 0) pending_results.push_back(mk(ST_EMPTY, 6'd0, 6'd0, 1'b1));
        else pending_results[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_wheel(it);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [6:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (addr == REG_SLOTS) slots_reg = value;
    else round_robin = value[0];
  endtask

  // Results are checked against the oldest prediction at each handshake.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: %p", out_data);
        errors++;
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          errors++;
        end
        if (out_data.visited_node !== e.visited_node) begin
          $error("visited_node expected %0d actual %0d", e.visited_node,
                 out_data.visited_node);
          errors++;
        end
        if (out_data.slot_index !== e.slot_index) begin
          $error("slot_index expected %0d actual %0d", e.slot_index, out_data.slot_index);
          errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // Receiver stalls in random bursts unless quiet is set.
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left <= int'($urandom_range(0, 5));
    end else begin
      out_ready <= 1'b1;
    end
  end

  typedef struct {
    logic [1:0] mode;
    logic [5:0] node;
    logic [6:0] adv;
    bit         typed;
    logic [1:0] st;
    logic [5:0] sl;
  } step_row_t;

  step_row_t directed [] = '{
    '{MODE_ADVANCE, 6'd0,  7'd0,  1'b1, ST_EMPTY, 6'd0},
    '{MODE_REMOVE,  6'd5,  7'd0,  1'b1, ST_STRAY, 6'd0},
    '{MODE_INSERT,  6'd0,  7'd0,  1'b1, ST_OK,    6'd0},
    '{MODE_INSERT,  6'd63, 7'd0,  1'b1, ST_OK,    6'd0},
    '{MODE_INSERT,  6'd0,  7'd0,  1'b1, ST_DUP,   6'd0},
    '{MODE_INSERT,  6'd21, 7'd127, 1'b0, ST_OK,   6'd0},
    '{MODE_ADVANCE, 6'd63, 7'd1,  1'b0, ST_OK,    6'd0},
    '{MODE_INSERT,  6'd42, 7'd0,  1'b1, ST_OK,    6'd1},
    '{MODE_REMOVE,  6'd63, 7'd0,  1'b0, ST_OK,    6'd0},
    '{MODE_REMOVE,  6'd63, 7'd0,  1'b1, ST_STRAY, 6'd0},
    '{MODE_IGNORED, 6'd7,  7'd5,  1'b0, ST_OK,    6'd0},
    '{MODE_ADVANCE, 6'd0,  7'd64, 1'b0, ST_OK,    6'd0},
    '{MODE_ADVANCE, 6'd0,  7'd127, 1'b0, ST_OK,   6'd0},
    '{MODE_REMOVE,  6'd21, 7'd0,  1'b0, ST_OK,    6'd0},
    '{MODE_REMOVE,  6'd0,  7'd0,  1'b0, ST_OK,    6'd0},
    '{MODE_REMOVE,  6'd42, 7'd0,  1'b0, ST_OK,    6'd0}
  };

  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.node_id = (r % 5 == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
    if (r < 45) it.mode = MODE_INSERT;
    else if (r < 75) it.mode = MODE_REMOVE;
    else if (r < 97) it.mode = MODE_ADVANCE;
    else it.mode = MODE_IGNORED;
    it.advance_slots = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 4));
    return it;
  endfunction

  initial begin
    in_item_t it;
    for (int s = 0; s < SLOTS; s++) head_of_slot[s] = EMPTY_HEAD;
    for (int v = 0; v < NODES; v++) node_on_wheel[v] = 1'b0;
    cursor = '0;
    ins_cursor = '0;
    slots_reg = 7'd64;
    round_robin = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      it.mode = directed[i].mode;
      it.node_id = directed[i].node;
      it.advance_slots = directed[i].adv;
      send_item(it);
      if (directed[i].typed && pending_results.size() != 0) begin
        if (pending_results[$].status !== directed[i].st) begin
          $error("directed row %0d: status expected %0d actual %0d",
                 i, directed[i].st, pending_results[$].status);
          errors++;
        end
        if (pending_results[$].slot_index !== directed[i].sl) begin
          $error("directed row %0d: slot_index expected %0d actual %0d",
                 i, directed[i].sl, pending_results[$].slot_index);
          errors++;
        end
      end
    end
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SLOTS, SLOT_SETTINGS[p]);
      write_reg(REG_MODE, 7'(p[0]));
      if (p == 5) quiet = 1'b1;
      for (int i = 0; i < 50; i++) send_item(random_item());
      drain();
    end

    if (errors == 0 && pending_results.size() == 0) begin
      $display("timing_wheel_slot_lists_tb: PASS");
    end else begin
      $display("timing_wheel_slot_lists_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timing_wheel_slot_lists_tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
design/tw_pkg.sv
design/timing_wheel_slot_lists.sv
dv/timing_wheel_slot_lists_tb.sv
